// ===== rtl/wpc_pkg.sv =====
// Shared types and constants for the window peak counter.
// Used by wpc_ctrl, wpc_dpath, window_peak_counter_core, wpc_checker and testbench; depends on nothing.
package wpc_pkg;

  // Fixed field widths of the result channel
  localparam int BEAT_W      = 7;
  localparam int MEAN_W      = 16;
  localparam int OUT_TDATA_W = 24;

  // Saturation point of the peak count
  localparam logic [BEAT_W-1:0] COUNT_MAX = 7'd127;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_MEAN,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;
    logic load;
    logic update;
    logic mean_load;
    logic scan_start;
    logic scan_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic scan_due;
    logic scan_done;
  } status_t;

endpackage

// ===== rtl/wpc_ctrl.sv =====
// Sequencing state machine for the window peak counter.
// Depends on wpc_pkg; drives wpc_dpath through cmd_t and reads status_t.
module wpc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  wpc_pkg::status_t sts,
  output wpc_pkg::cmd_t    cmd
);
  import wpc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   out_free;

  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign in_tready  = (state_r == ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_MEAN;
      ST_MEAN:  state_nxt = sts.scan_due ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (sts.scan_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE:  cmd.load = in_tvalid;
      ST_UPD:   cmd.update = 1'b1;
      ST_MEAN: begin
        cmd.mean_load  = 1'b1;
        cmd.scan_start = sts.scan_due;
      end
      ST_SCAN:  cmd.scan_step = 1'b1;
      ST_DONE:  cmd.out_load = out_free;
      default:  cmd = '0;
    endcase
  end

  // Hold the result valid until the request is taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// ===== rtl/wpc_dpath.sv =====
// Datapath of the window peak counter: sample window memory, running sum,
// reciprocal multiply for the mean, peak scan and result register. Depends on wpc_pkg.
module wpc_dpath #(
  parameter int WINDOW      = 100,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wpc_pkg::cmd_t                cmd,
  output wpc_pkg::status_t             sts,
  input  logic [SAMPLE_BITS-1:0]       sample,
  output logic [wpc_pkg::BEAT_W-1:0]   out_beat,
  output logic [wpc_pkg::MEAN_W-1:0]   out_mean,
  output logic                         out_flag
);
  import wpc_pkg::*;

  localparam int SCL_W = SAMPLE_BITS + 4;
  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = SCL_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  // Mean by reciprocal: floor(sum * ceil(2^SH / WINDOW) / 2^SH) is exact for sum < 2^SUM_W
  localparam int QT_W   = SUM_W - IDX_W + 1;
  localparam int RCP_W  = SUM_W + 1;
  localparam int MUL_SH = SUM_W + IDX_W;
  localparam int PRD_W  = SUM_W + RCP_W;
  localparam logic [63:0] RCP_WIDE =
    ((64'd1 << MUL_SH) + 64'(WINDOW - 1)) / 64'(WINDOW);
  localparam logic [RCP_W-1:0] RCP_K = RCP_W'(RCP_WIDE);

  // Sample window memory
  logic [SCL_W-1:0] win_mem [WINDOW];
  logic [SCL_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [SCL_W-1:0] wr_data;
  logic             wr_en;

  logic [SCL_W-1:0] scaled_r, scaled_nxt;
  logic [IDX_W-1:0] wr_pos_r, wr_pos_nxt;
  logic [IDX_W-1:0] clr_idx_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // Mean registers
  logic [PRD_W-1:0] prod;
  logic [QT_W-1:0]  mean_r;

  // Scan registers
  logic [IDX_W-1:0] saddr_r;
  logic             iss_done_r;
  logic             rv_r;
  logic [IDX_W-1:0] ridx_r;
  logic [SCL_W-1:0] p1_r, p2_r;
  logic [BEAT_W-1:0] cnt_r, cnt_nxt;
  logic [BEAT_W-1:0] beat_r;
  logic             flag_r;
  logic             is_peak;
  logic [QT_W+MEAN_W-1:0] q_ext;

  // Scale by ten as two shifted copies
  assign scaled_nxt = (SCL_W'(sample) << 3) + (SCL_W'(sample) << 1);
  assign sum_nxt    = sum_r - SUM_W'(rd_data_r) + SUM_W'(scaled_r);
  assign wr_pos_nxt = (wr_pos_r == LAST_IDX) ? '0 : wr_pos_r + 1'b1;

  // Memory port selection
  assign rd_addr = cmd.scan_step ? saddr_r : wr_pos_r;
  assign wr_en   = cmd.clr_wr || cmd.update;
  assign wr_addr = cmd.clr_wr ? clr_idx_r : wr_pos_r;
  assign wr_data = cmd.clr_wr ? '0 : scaled_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= win_mem[rd_addr];
  end

  // Divide the running sum by the window length
  assign prod = PRD_W'(sum_r) * PRD_W'(RCP_K);

  // Peak test: middle entry against mean and both neighbors
  assign is_peak = rv_r && (ridx_r >= IDX_W'(2)) &&
                   (SUM_W'(p2_r) > SUM_W'(mean_r)) && (p1_r < p2_r) && (p2_r > rd_data_r);

  always_comb begin
    cnt_nxt = cnt_r;
    if (is_peak && (cnt_r != COUNT_MAX)) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign sts.clr_done  = (clr_idx_r == LAST_IDX);
  assign sts.scan_due  = (wr_pos_r == LAST_IDX);
  assign sts.scan_done = rv_r && (ridx_r == LAST_IDX);

  // Control state: positions, sum, beat count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      wr_pos_r  <= '0;
      sum_r     <= '0;
      beat_r    <= '0;
      flag_r    <= 1'b0;
      rv_r      <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_idx_r <= clr_idx_r + 1'b1;
      if (cmd.update) begin
        wr_pos_r <= wr_pos_nxt;
        sum_r    <= sum_nxt;
        flag_r   <= 1'b0;
      end
      if (cmd.scan_start) begin
        flag_r <= 1'b1;
        rv_r   <= 1'b0;
      end else if (cmd.scan_step) begin
        rv_r <= !iss_done_r;
      end
      if (sts.scan_done) beat_r <= cnt_nxt;
    end
  end

  // Payload: sample latch, mean, scan pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) scaled_r <= scaled_nxt;
    if (cmd.mean_load) mean_r <= prod[MUL_SH +: QT_W];
    if (cmd.scan_start) begin
      saddr_r    <= '0;
      iss_done_r <= 1'b0;
      cnt_r      <= '0;
    end else if (cmd.scan_step) begin
      if (!iss_done_r) begin
        ridx_r <= saddr_r;
        if (saddr_r == LAST_IDX) iss_done_r <= 1'b1;
        else saddr_r <= saddr_r + 1'b1;
      end
      if (rv_r) begin
        p1_r  <= p2_r;
        p2_r  <= rd_data_r;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Result register
  assign q_ext = {{MEAN_W{1'b0}}, mean_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_beat <= beat_r;
      out_mean <= q_ext[MEAN_W-1:0];
      out_flag <= flag_r;
    end
  end

endmodule

// ===== rtl/window_peak_counter_core.sv =====
// Window peak counter: scaled moving-window mean and local-maximum count.
// An input request passes the update, mean (reciprocal multiply) and result load steps
// before the result request; on the sample that triggers a peak scan, a scan of the
// window memory (one memory read a cycle) comes before the result load. One item at a
// time: no new request is taken until the result is loaded, and a still-waiting result
// holds the final step. Reset (rst_n, synchronous, active low) starts a pass that zeroes
// the sample memory; no input request is taken until it ends.
module window_peak_counter_core #(
  parameter int WINDOW      = 100,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // adc_sample
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wpc_pkg::OUT_TDATA_W-1:0]     out_tdata,  // beat_count, window_mean
  output logic                                out_tuser   // count_updated
);
  import wpc_pkg::*;

  cmd_t              cmd;
  status_t           sts;
  logic [BEAT_W-1:0] beat;
  logic [MEAN_W-1:0] mean;

  wpc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  wpc_dpath #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .sample   (in_tdata[SAMPLE_BITS-1:0]),
    .out_beat (beat),
    .out_mean (mean),
    .out_flag (out_tuser)
  );

  // Pack the result, padded to whole bytes
  assign out_tdata = {{(OUT_TDATA_W-BEAT_W-MEAN_W){1'b0}}, mean, beat};

endmodule

// ===== test/wpc_checker.sv =====
`timescale 1ns / 100ps
// Checker for window_peak_counter_core: watches both stream channels, predicts each result.
// Depends on wpc_pkg for the result field widths and the peak count ceiling.
module wpc_checker #(
  parameter int WINDOW      = 100,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // adc_sample
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [wpc_pkg::OUT_TDATA_W-1:0]     out_tdata,  // beat_count, window_mean
  input  logic                                out_tuser,  // count_updated
  output int                                  fail_count,
  output int                                  pending_results
);
  import wpc_pkg::*;

  localparam int IN_W    = ((SAMPLE_BITS+7)/8)*8;
  localparam int ENTRY_W = SAMPLE_BITS + 4;
  localparam int SUM_W   = ENTRY_W + $clog2(WINDOW);
  localparam int POS_W   = $clog2(WINDOW);
  localparam int SCALE   = 10;

  typedef struct packed {
    logic [BEAT_W-1:0] beat_count;
    logic [MEAN_W-1:0] window_mean;
    logic              count_updated;
  } beat_result_t;

  // Shadow copy of the block's window state
  logic [ENTRY_W-1:0] win_mem [WINDOW];
  logic [POS_W-1:0]   wr_pos;
  logic [SUM_W-1:0]   win_sum;
  logic [BEAT_W-1:0]  last_beats;

  beat_result_t expected_q[$];
  int           mismatches;

  assign fail_count = mismatches;

  // Enter one sample into the shadow window and work out the result it yields
  function automatic beat_result_t enter_sample(input logic [IN_W-1:0] word);
    logic [ENTRY_W-1:0] scaled;
    logic [SUM_W-1:0]   mean;
    logic [BEAT_W-1:0]  peaks;
    beat_result_t       res;
    int                 k;
    scaled = ENTRY_W'(word[SAMPLE_BITS-1:0]) * ENTRY_W'(SCALE);
    // replace the oldest entry in the running sum
    win_sum = win_sum - SUM_W'(win_mem[wr_pos]) + SUM_W'(scaled);
    win_mem[wr_pos] = scaled;
    wr_pos = (wr_pos == POS_W'(WINDOW-1)) ? '0 : wr_pos + 1'b1;
    mean = win_sum / SUM_W'(WINDOW);
    res.count_updated = (wr_pos == POS_W'(WINDOW-1));
    // scan interior entries for strict local maxima above the mean
    if (res.count_updated) begin
      peaks = '0;
      for (k = 1; k < WINDOW-1; k++) begin
        if (SUM_W'(win_mem[k]) > mean && win_mem[k-1] < win_mem[k] &&
            win_mem[k] > win_mem[k+1] && peaks != COUNT_MAX)
          peaks = peaks + 1'b1;
      end
      last_beats = peaks;
    end
    res.beat_count  = last_beats;
    res.window_mean = MEAN_W'(mean);
    return res;
  endfunction

  // Predict on every input request, compare on every result request
  always @(posedge clk) begin : watch
    beat_result_t      want;
    logic [BEAT_W-1:0] got_beats;
    logic [MEAN_W-1:0] got_mean;
    if (!rst_n) begin
      foreach (win_mem[i]) win_mem[i] = '0;
      wr_pos      = '0;
      win_sum     = '0;
      last_beats  = '0;
      mismatches  = 0;
      expected_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_q.push_back(enter_sample(in_tdata));
      if (out_tvalid && out_tready) begin
        got_beats = out_tdata[BEAT_W-1:0];
        got_mean  = out_tdata[BEAT_W +: MEAN_W];
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: beat_count %0d, window_mean %0d",
                 got_beats, got_mean);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got_beats !== want.beat_count) begin
            $error("beat_count: expected %0d, actual %0d", want.beat_count, got_beats);
            mismatches++;
          end
          if (got_mean !== want.window_mean) begin
            $error("window_mean: expected %0d, actual %0d", want.window_mean, got_mean);
            mismatches++;
          end
          if (out_tuser !== want.count_updated) begin
            $error("count_updated: expected %0d, actual %0d", want.count_updated, out_tuser);
            mismatches++;
          end
        end
      end
    end
    pending_results <= expected_q.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Top of the window peak counter bench: clock, reset, sample waveforms and the verdict.
// Depends on wpc_pkg, window_peak_counter_core and wpc_checker.
module testbench;
  import wpc_pkg::*;

  localparam int WINDOW        = 100;
  localparam int SAMPLE_BITS   = 12;
  localparam int IN_W          = ((SAMPLE_BITS+7)/8)*8;
  localparam int TOTAL_SAMPLES = 1650;
  localparam int DRAIN_EVERY   = 400;
  localparam int SETTLE_CYCLES = 160;

  typedef enum {WAVE_NOISE, WAVE_PULSE, WAVE_ZIGZAG, WAVE_FLAT, WAVE_TWIN, WAVE_RAMP} wave_t;
  typedef enum {RDY_FREE, RDY_MOSTLY, RDY_SPARSE, RDY_LONG_STALL} ready_mode_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_W-1:0]        in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  int                     fail_count;
  int                     pending_results;

  int          samples_sent = 0;
  int          burst_left   = 0;
  ready_mode_t ready_mode;
  int          mode_left;
  int          stall_left;

  window_peak_counter_core #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  wpc_checker #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side back-pressure: switch between free flow, random and long stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_mode <= RDY_FREE;
      mode_left  <= 50;
      stall_left <= 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        RDY_FREE:   out_tready <= 1'b1;
        RDY_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
        RDY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_left == 0) begin
            out_tready <= 1'b1;
            stall_left <= $urandom_range(5, 60);
          end else begin
            out_tready <= 1'b0;
            stall_left <= stall_left - 1;
          end
        end
      endcase
    end
  end

  // Offer one request and hold it until taken; then maybe open a gap
  task automatic send_word(input logic [IN_W-1:0] word);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(0, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Send a converter reading, sometimes with junk in the unused upper bits
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
    logic [IN_W-1:0] word;
    word = IN_W'(sample);
    if ($urandom_range(0, 3) == 0)
      word[IN_W-1:SAMPLE_BITS] = (IN_W-SAMPLE_BITS)'($urandom);
    send_word(word);
  endtask

  // Hold the sender off until every outstanding result has come back
  task automatic drain_results;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // One stretch of a waveform of the given shape with random shape parameters
  task automatic send_wave(input wave_t shape, input int len);
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] level;
    int                     period;
    int                     k;
    lo     = SAMPLE_BITS'($urandom_range(0, 1500));
    hi     = SAMPLE_BITS'($urandom_range(1600, 4095));
    level  = SAMPLE_BITS'($urandom_range(0, 4095));
    period = $urandom_range(3, 25);
    for (k = 0; k < len; k++) begin
      case (shape)
        WAVE_NOISE:  send_sample(SAMPLE_BITS'($urandom_range(0, 4095)));
        WAVE_PULSE:  send_sample((k % period == 0) ? hi
                                 : lo + SAMPLE_BITS'($urandom_range(0, 15)));
        WAVE_ZIGZAG: send_sample(k[0] ? hi - SAMPLE_BITS'($urandom_range(0, 7)) : lo);
        WAVE_FLAT:   send_sample(level);
        // flat-topped pulses: equal neighbors never count as a peak
        WAVE_TWIN:   send_sample((k % period < 2) ? hi : lo);
        default:     send_sample(SAMPLE_BITS'(k * period * 7));
      endcase
    end
  endtask

  initial begin : stimulus
    logic [IN_W-1:0] directed_words [19];
    int              last_drain;
    directed_words = '{16'h0000, 16'h0FFF, 16'hFFFF, 16'hF000, 16'h0001, 16'h0FFE,
                       16'h0800, 16'h07FF, 16'h0BB8, 16'h0BB8, 16'h0064, 16'h0FFF,
                       16'h0000, 16'h0FFF, 16'h0000, 16'h0FFF, 16'hA555, 16'h5AAA,
                       16'h0000};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, ignored upper bits, ties and a short zigzag
    foreach (directed_words[i]) send_word(directed_words[i]);
    drain_results;
    last_drain = samples_sent;

    // random waveform segments; scans land wherever the window wraps
    while (samples_sent < TOTAL_SAMPLES) begin
      send_wave(wave_t'($urandom_range(0, 5)), $urandom_range(10, 150));
      if (samples_sent - last_drain >= DRAIN_EVERY) begin
        drain_results;
        last_drain = samples_sent;
      end
    end

    drain_results;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wpc_pkg.sv
rtl/wpc_ctrl.sv
rtl/wpc_dpath.sv
rtl/window_peak_counter_core.sv
test/wpc_checker.sv
test/testbench.sv
